[sv/rsamp_pkg.sv]
`default_nettype none

package rsamp_pkg;

	localparam int FEATURE_COUNT = 6;
	localparam int INDEX_BITS    = 16;

	localparam int SEED_W   = 32;
	localparam int BANK_W   = 16;
	localparam int LIMIT_W  = 3;
	localparam int TAG_W    = 16;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;

	// Divider operand widths: xorshift word over a bank-sized bound
	localparam int DVD_W  = SEED_W;
	localparam int BOUND_W = BANK_W;
	localparam int DIV_CNT_W = $clog2(DVD_W);

	localparam int COUNT_W = $clog2(FEATURE_COUNT + 1);
	localparam int FEAT_AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

	localparam logic [SEED_W-1:0] ZERO_FILL = 32'd2463534242;
	localparam int XS_A = 13;
	localparam int XS_B = 17;
	localparam int XS_C = 5;

	localparam logic [SEED_W-1:0]  SEED_RST  = 32'd1;
	localparam logic [BANK_W-1:0]  VERB_RST  = 16'd34;
	localparam logic [BANK_W-1:0]  NOUN_RST  = 16'd31;
	localparam logic [BANK_W-1:0]  ADJ_RST   = 16'd28;
	localparam logic [LIMIT_W-1:0] MIN_RST   = 3'd1;
	localparam logic [LIMIT_W-1:0] MAX_RST   = 3'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERB = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOUN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ADJ  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX  = 3'd5;

	localparam int PC_W = 5;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_INIT,
		OP_DRAW,
		OP_WAIT,
		OP_READ,
		OP_SWAP1,
		OP_SWAP2,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		SRC_VERB,
		SRC_NOUN,
		SRC_ADJ,
		SRC_SIZE,
		SRC_FEAT
	} src_t;

	typedef enum logic {
		RD_K,
		RD_J
	} rd_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_IN,
		C_DIV_BUSY,
		C_INIT_MORE,
		C_K_DONE,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		op_t             op;
		src_t            src;
		rd_t             rd;
		cond_t           cond;
		logic            clr_k;
		logic [PC_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic div_busy;
		logic init_more;
		logic k_done;
		logic out_full;
	} stat_t;

	// Program step addresses
	localparam logic [PC_W-1:0] ST_ACCEPT = 5'd0;
	localparam logic [PC_W-1:0] ST_INIT   = 5'd1;
	localparam logic [PC_W-1:0] ST_DVERB  = 5'd2;
	localparam logic [PC_W-1:0] ST_WVERB  = 5'd3;
	localparam logic [PC_W-1:0] ST_DNOUN  = 5'd4;
	localparam logic [PC_W-1:0] ST_WNOUN  = 5'd5;
	localparam logic [PC_W-1:0] ST_DADJ   = 5'd6;
	localparam logic [PC_W-1:0] ST_WADJ   = 5'd7;
	localparam logic [PC_W-1:0] ST_DSIZE  = 5'd8;
	localparam logic [PC_W-1:0] ST_WSIZE  = 5'd9;
	localparam logic [PC_W-1:0] ST_TEST   = 5'd10;
	localparam logic [PC_W-1:0] ST_DFEAT  = 5'd11;
	localparam logic [PC_W-1:0] ST_WFEAT  = 5'd12;
	localparam logic [PC_W-1:0] ST_READJ  = 5'd13;
	localparam logic [PC_W-1:0] ST_SWAP1  = 5'd14;
	localparam logic [PC_W-1:0] ST_SWAP2  = 5'd15;
	localparam logic [PC_W-1:0] ST_EMIT   = 5'd16;
	localparam logic [PC_W-1:0] ST_LOOP   = 5'd17;

	function automatic ctl_t mk(input op_t op, input src_t src, input rd_t rd,
		input cond_t cond, input logic clr_k, input logic [PC_W-1:0] target);
		ctl_t w;
		w.op     = op;
		w.src    = src;
		w.rd     = rd;
		w.cond   = cond;
		w.clr_k  = clr_k;
		w.target = target;
		return w;
	endfunction

	// Control store: one word per step
	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t w;
		w = mk(OP_NOP, SRC_VERB, RD_K, C_ALWAYS, 1'b0, ST_ACCEPT);
		unique case (pc)
			ST_ACCEPT: w = mk(OP_ACCEPT, SRC_VERB, RD_K, C_NO_IN,     1'b0, ST_ACCEPT);
			ST_INIT:   w = mk(OP_INIT,   SRC_VERB, RD_K, C_INIT_MORE, 1'b0, ST_INIT);
			ST_DVERB:  w = mk(OP_DRAW,   SRC_VERB, RD_K, C_NEXT,      1'b1, ST_ACCEPT);
			ST_WVERB:  w = mk(OP_WAIT,   SRC_VERB, RD_K, C_DIV_BUSY,  1'b0, ST_WVERB);
			ST_DNOUN:  w = mk(OP_DRAW,   SRC_NOUN, RD_K, C_NEXT,      1'b0, ST_ACCEPT);
			ST_WNOUN:  w = mk(OP_WAIT,   SRC_NOUN, RD_K, C_DIV_BUSY,  1'b0, ST_WNOUN);
			ST_DADJ:   w = mk(OP_DRAW,   SRC_ADJ,  RD_K, C_NEXT,      1'b0, ST_ACCEPT);
			ST_WADJ:   w = mk(OP_WAIT,   SRC_ADJ,  RD_K, C_DIV_BUSY,  1'b0, ST_WADJ);
			ST_DSIZE:  w = mk(OP_DRAW,   SRC_SIZE, RD_K, C_NEXT,      1'b0, ST_ACCEPT);
			ST_WSIZE:  w = mk(OP_WAIT,   SRC_SIZE, RD_K, C_DIV_BUSY,  1'b0, ST_WSIZE);
			ST_TEST:   w = mk(OP_READ,   SRC_FEAT, RD_K, C_K_DONE,    1'b0, ST_EMIT);
			ST_DFEAT:  w = mk(OP_DRAW,   SRC_FEAT, RD_K, C_NEXT,      1'b0, ST_ACCEPT);
			ST_WFEAT:  w = mk(OP_WAIT,   SRC_FEAT, RD_K, C_DIV_BUSY,  1'b0, ST_WFEAT);
			ST_READJ:  w = mk(OP_READ,   SRC_FEAT, RD_J, C_NEXT,      1'b0, ST_ACCEPT);
			ST_SWAP1:  w = mk(OP_SWAP1,  SRC_FEAT, RD_K, C_NEXT,      1'b0, ST_ACCEPT);
			ST_SWAP2:  w = mk(OP_SWAP2,  SRC_FEAT, RD_K, C_ALWAYS,    1'b0, ST_TEST);
			ST_EMIT:   w = mk(OP_EMIT,   SRC_VERB, RD_K, C_OUT_FULL,  1'b0, ST_EMIT);
			ST_LOOP:   w = mk(OP_NOP,    SRC_VERB, RD_K, C_ALWAYS,    1'b0, ST_ACCEPT);
			default:   w = mk(OP_NOP,    SRC_VERB, RD_K, C_ALWAYS,    1'b0, ST_ACCEPT);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[sv/random_index_and_subset_sampler_core.sv]
// Random index and subset sampler.
// Each request beat (in_valid/in_stall, tag request_id) yields one result beat
// (out_valid/out_stall) with three bank indices, a feature mask and its count.
// A 32-bit xorshift generator feeds every draw; each draw is reduced modulo its
// bound by a shared bit-serial remainder unit. A zero bound gives 0 and does
// not step the generator. A microcoded sequencer walks the request: identity
// fill of the 6-entry feature-order RAM, three bank draws, a subset-size draw,
// then one partial Fisher-Yates swap per chosen feature. Requests are taken
// one at a time. The next request is taken once the result is posted to the
// output register, so a waiting result does not block the next request.
// If the receiver stalls, the result holds and the sequencer waits before
// posting the following one. Configuration writes (cfg_we/cfg_index/cfg_data)
// must go in only while idle; the user keeps to this, the block does not
// enforce it. Writing the seed register reloads the generator. Reset
// restores all register defaults and a generator state of 1.
`default_nettype none

module random_index_and_subset_sampler_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [rsamp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rsamp_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [rsamp_pkg::TAG_W-1:0]      request_id,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [rsamp_pkg::TAG_W-1:0]      request_tag,
	output logic      [rsamp_pkg::INDEX_BITS-1:0] verb_index,
	output logic      [rsamp_pkg::INDEX_BITS-1:0] noun_index,
	output logic      [rsamp_pkg::INDEX_BITS-1:0] adjective_index,
	output logic      [rsamp_pkg::FEATURE_COUNT-1:0] feature_mask,
	output logic      [rsamp_pkg::COUNT_W-1:0]    feature_count
);
	import rsamp_pkg::*;

	// configuration
	logic [BANK_W-1:0]  verb_size_q, noun_size_q, adj_size_q;
	logic [LIMIT_W-1:0] min_q, max_q;

	// generator and working state
	logic [SEED_W-1:0]  rng_q;
	logic [TAG_W-1:0]   tag_q;
	logic [BOUND_W-1:0] verb_q, noun_q, adj_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] k_q;
	logic [FEAT_AW-1:0] j_q;
	logic [FEAT_AW-1:0] ok_q;
	logic [FEATURE_COUNT-1:0] mask_q;

	// result register
	logic                     out_valid_q;
	logic [TAG_W-1:0]         out_tag_q;
	logic [INDEX_BITS-1:0]    out_verb_q, out_noun_q, out_adj_q;
	logic [FEATURE_COUNT-1:0] out_mask_q;
	logic [COUNT_W-1:0]       out_count_q;

	ctl_t  ctl;
	stat_t stat;

	logic [SEED_W-1:0]  x0, x1, x2, rng_adv;
	logic [COUNT_W-1:0] lo, hi_sat, hi;
	logic [BOUND_W-1:0] size_bound, feat_bound, bound;
	logic               div_start, div_busy;
	logic [BOUND_W-1:0] div_rem;
	logic [BOUND_W-1:0] j_sum;
	logic               accepted, out_full, do_emit;

	logic               ram_we, ram_re;
	logic [FEAT_AW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

	rsamp_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	rsamp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rng_adv),
		.divisor  (bound),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	rsamp_ram #(
		.WIDTH (FEAT_AW),
		.DEPTH (FEATURE_COUNT)
	) u_order (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// xorshift step; a zero state is swapped for the fill constant first
	always_comb begin
		x0      = (rng_q == '0) ? ZERO_FILL : rng_q;
		x1      = x0 ^ (x0 << XS_A);
		x2      = x1 ^ (x1 >> XS_B);
		rng_adv = x2 ^ (x2 << XS_C);
	end

	// subset limits: saturate both to the feature count, raise max to min
	always_comb begin
		lo     = (32'(min_q) > 32'(FEATURE_COUNT)) ? COUNT_W'(FEATURE_COUNT) : COUNT_W'(min_q);
		hi_sat = (32'(max_q) > 32'(FEATURE_COUNT)) ? COUNT_W'(FEATURE_COUNT) : COUNT_W'(max_q);
		hi     = (hi_sat < lo) ? lo : hi_sat;
		size_bound = BOUND_W'(hi) - BOUND_W'(lo) + 1'b1;
		feat_bound = BOUND_W'(FEATURE_COUNT) - BOUND_W'(k_q);
	end

	always_comb begin
		unique case (ctl.src)
			SRC_VERB: bound = verb_size_q;
			SRC_NOUN: bound = noun_size_q;
			SRC_ADJ:  bound = adj_size_q;
			SRC_SIZE: bound = size_bound;
			SRC_FEAT: bound = feat_bound;
			default:  bound = '0;
		endcase
	end

	assign j_sum = BOUND_W'(k_q) + div_rem;

	// handshake
	assign in_stall  = (ctl.op != OP_ACCEPT);
	assign accepted  = in_valid && !in_stall;
	assign out_full  = out_valid_q && out_stall;
	assign do_emit   = (ctl.op == OP_EMIT) && !out_full;
	assign div_start = (ctl.op == OP_DRAW);

	always_comb begin
		stat.in_valid  = in_valid;
		stat.div_busy  = div_busy;
		stat.init_more = (k_q != COUNT_W'(FEATURE_COUNT - 1));
		stat.k_done    = (k_q >= count_q);
		stat.out_full  = out_full;
	end

	// feature-order RAM control: identity fill, then swap pairs
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_q[FEAT_AW-1:0];
		ram_wdata = k_q[FEAT_AW-1:0];
		unique case (ctl.op)
			OP_INIT: begin
				ram_we = 1'b1;
			end
			OP_SWAP1: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			OP_SWAP2: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = ok_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		ram_re    = (ctl.op == OP_READ);
		ram_raddr = (ctl.rd == RD_J) ? j_q : k_q[FEAT_AW-1:0];
	end

	// configuration registers and generator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q       <= SEED_RST;
			verb_size_q <= VERB_RST;
			noun_size_q <= NOUN_RST;
			adj_size_q  <= ADJ_RST;
			min_q       <= MIN_RST;
			max_q       <= MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEED: rng_q       <= cfg_data[SEED_W-1:0];
				REG_VERB: verb_size_q <= cfg_data[BANK_W-1:0];
				REG_NOUN: noun_size_q <= cfg_data[BANK_W-1:0];
				REG_ADJ:  adj_size_q  <= cfg_data[BANK_W-1:0];
				REG_MIN:  min_q       <= cfg_data[LIMIT_W-1:0];
				REG_MAX:  max_q       <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end else if (div_start && (bound != '0)) begin
			// advance the generator only for a nonzero bound
			rng_q <= rng_adv;
		end
	end

	// loop counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (accepted || ctl.clr_k) begin
			k_q <= '0;
		end else if ((ctl.op == OP_INIT) || (ctl.op == OP_SWAP2)) begin
			k_q <= k_q + 1'b1;
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		if (accepted) begin
			tag_q  <= request_id;
			mask_q <= '0;
		end
		if ((ctl.op == OP_DRAW) && (ctl.src == SRC_FEAT)) begin
			// hold order[k], read in the test step
			ok_q <= ram_rdata;
		end
		if ((ctl.op == OP_WAIT) && !div_busy) begin
			unique case (ctl.src)
				SRC_VERB: verb_q  <= div_rem;
				SRC_NOUN: noun_q  <= div_rem;
				SRC_ADJ:  adj_q   <= div_rem;
				SRC_SIZE: count_q <= lo + div_rem[COUNT_W-1:0];
				SRC_FEAT: j_q     <= j_sum[FEAT_AW-1:0];
				default: begin
				end
			endcase
		end
		if (ctl.op == OP_SWAP1) begin
			// the element moved into slot k is chosen
			mask_q <= mask_q | (FEATURE_COUNT'(1) << ram_rdata);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			out_tag_q   <= tag_q;
			out_verb_q  <= INDEX_BITS'(verb_q);
			out_noun_q  <= INDEX_BITS'(noun_q);
			out_adj_q   <= INDEX_BITS'(adj_q);
			out_mask_q  <= mask_q;
			out_count_q <= count_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign request_tag     = out_tag_q;
	assign verb_index      = out_verb_q;
	assign noun_index      = out_noun_q;
	assign adjective_index = out_adj_q;
	assign feature_mask    = out_mask_q;
	assign feature_count   = out_count_q;

endmodule

`default_nettype wire

[sv/rsamp_ram.sv]
`default_nettype none

module rsamp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/rsamp_div.sv]
`default_nettype none

module rsamp_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [rsamp_pkg::DVD_W-1:0]   dividend,
	input  wire logic [rsamp_pkg::BOUND_W-1:0] divisor,
	output logic                              busy,
	output logic      [rsamp_pkg::BOUND_W-1:0] rem
);
	import rsamp_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [BOUND_W-1:0]   bnd_q;
	logic [BOUND_W-1:0]   rem_q;
	logic [BOUND_W:0]     trial;
	logic [BOUND_W:0]     diff;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, bnd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= (divisor != '0);
			cnt_q  <= DIV_CNT_W'(DVD_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			bnd_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			if (trial >= {1'b0, bnd_q}) begin
				rem_q <= diff[BOUND_W-1:0];
			end else begin
				rem_q <= trial[BOUND_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

[sv/rsamp_useq.sv]
`default_nettype none

module rsamp_useq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rsamp_pkg::stat_t stat,
	output rsamp_pkg::ctl_t       ctl
);
	import rsamp_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            take;

	assign ctl = ucode(pc_q);

	always_comb begin
		unique case (ctl.cond)
			C_NEXT:      take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_IN:     take = !stat.in_valid;
			C_DIV_BUSY:  take = stat.div_busy;
			C_INIT_MORE: take = stat.init_more;
			C_K_DONE:    take = stat.k_done;
			C_OUT_FULL:  take = stat.out_full;
			default:     take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_ACCEPT;
		end else if (take) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

`default_nettype wire
